/* rtl/pnp_pkg.sv */
// shared constants and types for the prefixed number parser
package pnp_pkg;

   localparam int CH_WIDTH     = 8;
   localparam int BASE_WIDTH   = 6;
   localparam int CELL_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 8;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_SINGLE = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DOUBLE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_ERROR  = 2'd2;

   // characters with a special role
   localparam logic [CH_WIDTH-1:0] CH_HASH    = 8'h23;
   localparam logic [CH_WIDTH-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [CH_WIDTH-1:0] CH_PERCENT = 8'h25;
   localparam logic [CH_WIDTH-1:0] CH_AMP     = 8'h26;
   localparam logic [CH_WIDTH-1:0] CH_QUOTE   = 8'h27;
   localparam logic [CH_WIDTH-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_WIDTH-1:0] CH_DOT     = 8'h2E;

   localparam logic [BASE_WIDTH-1:0] BASE_BIN   = 6'd2;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_WIDTH-1:0] RESET_BASE = 6'd10;

   localparam logic [CELL_WIDTH-1:0] CELL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [CELL_WIDTH-1:0]   value_low;
      logic [CELL_WIDTH-1:0]   value_high;
      logic [COUNT_WIDTH-1:0]  remaining;
   } result_type;

endpackage

/* rtl/pnp_req_if.sv */
// character word channel into the parser
interface pnp_req_if;
   logic                          valid;
   logic                          ready;
   logic [pnp_pkg::CH_WIDTH-1:0]  ch;
   logic                          last_char;
   logic                          empty_token;

   modport source (output valid, output ch, output last_char, output empty_token,
                   input ready);
   modport sink (input valid, input ch, input last_char, input empty_token,
                 output ready);
endinterface

/* rtl/pnp_rsp_if.sv */
// result word channel out of the parser
interface pnp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pnp_pkg::STATUS_WIDTH-1:0]  status;
   logic [pnp_pkg::CELL_WIDTH-1:0]    value_low;
   logic [pnp_pkg::CELL_WIDTH-1:0]    value_high;
   logic [pnp_pkg::COUNT_WIDTH-1:0]   remaining;

   modport source (output valid, output status, output value_low, output value_high,
                   output remaining, input ready);
   modport sink (input valid, input status, input value_low, input value_high,
                 input remaining, output ready);
endinterface

/* rtl/prefixed_number_parser_core.sv */
// a final or empty word is registered at the input, then parsed, and its result is registered at the output
// throughput: one character word per cycle; words that end no token leave nothing on the output
// a result held back by the receiver stalls the parse stage, and the input one word later
// each word is parsed in one pass: a 32 by 6 bit multiply-add and a few compares
// reset (synchronous, active high) clears the parse state and sets the default base to 10
module prefixed_number_parser_core #(
   parameter int MAX_TOKEN_LENGTH = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   pnp_req_if.sink                           req_if,
   pnp_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [pnp_pkg::BASE_WIDTH-1:0]    csr_wr_data
);

   logic [pnp_pkg::BASE_WIDTH-1:0] base_ff;
   logic                           in_vld_ff;
   logic [pnp_pkg::CH_WIDTH-1:0]   in_ch_ff;
   logic                           in_last_ff;
   logic                           in_empty_ff;
   logic                           out_vld_ff;
   logic                           out_vld_in;
   pnp_pkg::result_type            out_res_ff;

   logic                           go;
   logic                           res_fire;
   pnp_pkg::result_type            res;

   assign go           = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready = !reset && (!in_vld_ff || go);
   assign out_vld_in   = (go && res_fire) ? 1'b1 : (rsp_if.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= pnp_pkg::RESET_BASE;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_ch_ff    <= req_if.ch;
         in_last_ff  <= req_if.last_char;
         in_empty_ff <= req_if.empty_token;
      end
   end

   pnp_parser #(
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .ch           (in_ch_ff),
      .last_char    (in_last_ff),
      .empty_token  (in_empty_ff),
      .default_base (base_ff),
      .res_fire     (res_fire),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && res_fire) begin
         out_res_ff <= res;
      end
   end

   assign rsp_if.valid      = out_vld_ff;
   assign rsp_if.status     = out_res_ff.status;
   assign rsp_if.value_low  = out_res_ff.value_low;
   assign rsp_if.value_high = out_res_ff.value_high;
   assign rsp_if.remaining  = out_res_ff.remaining;

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_res_ff.status == pnp_pkg::ST_SINGLE ||
                     out_res_ff.status == pnp_pkg::ST_DOUBLE ||
                     out_res_ff.status == pnp_pkg::ST_ERROR)
      else $error("undefined result status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_res_ff.status == pnp_pkg::ST_ERROR |->
         out_res_ff.value_low == '0 && out_res_ff.value_high == '0)
      else $error("error result carries a value");

   a_high_only_double: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_res_ff.value_high != '0 |-> out_res_ff.status == pnp_pkg::ST_DOUBLE)
      else $error("high cell set on a non-double result");

   a_empty_gives_error: assert property (@(posedge clock) disable iff (reset)
      go && in_empty_ff |=> out_vld_ff && out_res_ff.status == pnp_pkg::ST_ERROR &&
                            out_res_ff.remaining == '0)
      else $error("empty token did not give an error result");

endmodule

/* rtl/pnp_parser.sv */
// per-character parse state and the combinational step logic
module pnp_parser #(
   parameter int MAX_TOKEN_LENGTH = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic [pnp_pkg::CH_WIDTH-1:0]         ch,
   input  logic                                 last_char,
   input  logic                                 empty_token,
   input  logic [pnp_pkg::BASE_WIDTH-1:0]       default_base,
   output logic                                 res_fire,
   output pnp_pkg::result_type                  res
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SIGN,
      PH_QCHAR,
      PH_QCLOSE,
      PH_DIGIT,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type                               phase;
      logic [pnp_pkg::BASE_WIDTH-1:0]          radix;
      logic [pnp_pkg::CELL_WIDTH-1:0]          acc;
      logic                                    neg;
      logic [pnp_pkg::STATUS_WIDTH-1:0]        outcome;
      logic [pnp_pkg::COUNT_WIDTH-1:0]         leftover;
   } state_type;

   localparam state_type CLEARED = '{
      phase:    PH_FIRST,
      radix:    pnp_pkg::RESET_BASE,
      acc:      '0,
      neg:      1'b0,
      outcome:  pnp_pkg::ST_SINGLE,
      leftover: '0
   };

   localparam logic [pnp_pkg::COUNT_WIDTH-1:0] LEFT_MAX =
      pnp_pkg::COUNT_WIDTH'(MAX_TOKEN_LENGTH);

   function automatic state_type decided(
      input logic [pnp_pkg::STATUS_WIDTH-1:0] sts,
      input logic [pnp_pkg::CELL_WIDTH-1:0]   v,
      input logic                             neg,
      input logic [pnp_pkg::BASE_WIDTH-1:0]   r
   );
      state_type s;
      s.phase    = PH_DONE;
      s.radix    = r;
      s.acc      = v;
      s.neg      = neg;
      s.outcome  = sts;
      s.leftover = '0;
      return s;
   endfunction

   state_type st_ff;
   state_type st_in;
   state_type nx;
   state_type fin;
   state_type base_st;
   state_type dig_st;
   state_type sgn_st;

   logic                                first_ph;
   logic [pnp_pkg::BASE_WIDTH-1:0]      radix_eff;
   logic [pnp_pkg::CELL_WIDTH-1:0]      acc_eff;
   logic                                neg_eff;
   logic [6:0]                          dval;
   logic [pnp_pkg::CELL_WIDTH-1:0]      mac;
   logic [pnp_pkg::CELL_WIDTH-1:0]      qval;
   logic [pnp_pkg::BASE_WIDTH-1:0]      pfx_radix;

   // the first character latches the default base and starts from zero
   assign first_ph  = (st_ff.phase == PH_FIRST);
   assign radix_eff = first_ph ? default_base : st_ff.radix;
   assign acc_eff   = first_ph ? '0 : st_ff.acc;
   assign neg_eff   = first_ph ? 1'b0 : st_ff.neg;

   always_comb begin
      if (ch inside {[8'h30:8'h39]}) begin
         dval = 7'(ch - 8'h30);
      end else if (ch inside {[8'h41:8'h5A]}) begin
         dval = 7'(ch - 8'h37);
      end else if (ch inside {[8'h61:8'h7A]}) begin
         dval = 7'(ch - 8'h57);
      end else begin
         dval = 7'd64;
      end
   end

   assign mac  = acc_eff * {26'd0, radix_eff} + {25'd0, dval};
   assign qval = {{24{ch[7]}}, ch};

   always_comb begin
      if (ch == pnp_pkg::CH_DOLLAR) begin
         pfx_radix = pnp_pkg::BASE_HEX;
      end else if (ch == pnp_pkg::CH_PERCENT) begin
         pfx_radix = pnp_pkg::BASE_BIN;
      end else begin
         pfx_radix = pnp_pkg::BASE_DEC;
      end
   end

   always_comb begin
      base_st       = st_ff;
      base_st.phase = PH_DIGIT;
      base_st.radix = radix_eff;
      base_st.acc   = acc_eff;
      base_st.neg   = neg_eff;

      // digit phase step
      if (ch == pnp_pkg::CH_DOT) begin
         dig_st = decided(pnp_pkg::ST_DOUBLE, neg_eff ? 32'd0 - acc_eff : acc_eff,
                          neg_eff, radix_eff);
      end else if (dval >= {1'b0, radix_eff}) begin
         dig_st = decided(pnp_pkg::ST_ERROR, '0, 1'b0, radix_eff);
      end else if (last_char) begin
         dig_st = decided(pnp_pkg::ST_SINGLE, neg_eff ? 32'd0 - mac : mac, 1'b0,
                          radix_eff);
      end else begin
         dig_st     = base_st;
         dig_st.acc = mac;
      end

      // optional minus ahead of the digits
      if (ch == pnp_pkg::CH_MINUS) begin
         if (last_char) begin
            sgn_st = decided(pnp_pkg::ST_ERROR, '0, 1'b0, radix_eff);
         end else begin
            sgn_st     = base_st;
            sgn_st.neg = 1'b1;
         end
      end else begin
         sgn_st = dig_st;
      end
   end

   always_comb begin
      nx = st_ff;
      case (st_ff.phase)
         PH_FIRST: begin
            if (ch == pnp_pkg::CH_HASH || ch == pnp_pkg::CH_AMP ||
                ch == pnp_pkg::CH_DOLLAR || ch == pnp_pkg::CH_PERCENT) begin
               if (last_char) begin
                  nx = decided(pnp_pkg::ST_ERROR, '0, 1'b0, pfx_radix);
               end else begin
                  nx.phase = PH_SIGN;
                  nx.radix = pfx_radix;
                  nx.acc   = '0;
                  nx.neg   = 1'b0;
               end
            end else if (ch == pnp_pkg::CH_QUOTE) begin
               if (last_char) begin
                  nx = decided(pnp_pkg::ST_ERROR, '0, 1'b0, st_ff.radix);
               end else begin
                  nx.phase = PH_QCHAR;
                  nx.acc   = '0;
                  nx.neg   = 1'b0;
               end
            end else begin
               nx = sgn_st;
            end
         end
         PH_QCHAR: begin
            if (last_char) begin
               nx = decided(pnp_pkg::ST_SINGLE, qval, 1'b0, st_ff.radix);
            end else begin
               nx.phase = PH_QCLOSE;
               nx.acc   = qval;
            end
         end
         PH_QCLOSE: begin
            // anything but a closing quote spoils the literal
            if (ch == pnp_pkg::CH_QUOTE) begin
               nx = decided(pnp_pkg::ST_SINGLE, st_ff.acc, 1'b0, st_ff.radix);
            end else begin
               nx = decided(pnp_pkg::ST_ERROR, '0, 1'b0, st_ff.radix);
            end
         end
         PH_SIGN:  nx = sgn_st;
         PH_DIGIT: nx = dig_st;
         default: begin
            if (st_ff.leftover < LEFT_MAX) begin
               nx.leftover = st_ff.leftover + 8'd1;
            end
         end
      endcase
   end

   always_comb begin
      fin      = (nx.phase == PH_DONE) ? nx
                 : decided(pnp_pkg::ST_ERROR, '0, 1'b0, nx.radix);
      res_fire = empty_token || last_char;
      if (empty_token) begin
         res.status     = pnp_pkg::ST_ERROR;
         res.value_low  = '0;
         res.value_high = '0;
         res.remaining  = '0;
         st_in          = CLEARED;
      end else begin
         res.status     = fin.outcome;
         res.value_low  = (fin.outcome == pnp_pkg::ST_ERROR) ? '0 : fin.acc;
         res.value_high = (fin.outcome == pnp_pkg::ST_DOUBLE && fin.neg)
                          ? pnp_pkg::CELL_ONES : '0;
         res.remaining  = fin.leftover;
         st_in          = last_char ? CLEARED : nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CLEARED;
      end else if (go) begin
         st_ff <= st_in;
      end
   end

   // a finished or abandoned token always leaves the parser ready for a new one
   a_token_end_clears: assert property (@(posedge clock) disable iff (reset)
      go && (last_char || empty_token) |=> st_ff.phase == PH_FIRST && st_ff.acc == '0)
      else $error("parse state not cleared after token end");

   // remaining count only moves once the result is decided
   a_leftover_only_done: assert property (@(posedge clock) disable iff (reset)
      st_ff.leftover != '0 |-> st_ff.phase == PH_DONE)
      else $error("leftover counted before decision");

endmodule

/* tb/prefixed_number_parser_core_tb.sv */
// self-checking testbench for the prefixed number parser core
`timescale 1ns / 100ps

module prefixed_number_parser_core_tb;

   localparam int MAX_TOKEN_LEN  = 255;
   localparam int SETTLE_CYCLES  = 4;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 100;
   localparam int NUM_PHASES     = 8;

   localparam logic [pnp_pkg::BASE_WIDTH-1:0] PHASE_BASES [0:6] =
      '{6'd2, 6'd36, 6'd10, 6'd16, 6'd63, 6'd1, 6'd0};

   typedef enum logic [2:0] {
      WAIT_FIRST, WAIT_SIGN, WAIT_QCHAR, WAIT_QCLOSE, IN_DIGITS, DECIDED
   } parse_phase_type;

   typedef enum bit {ROW_WORD, ROW_CFG} row_kind_type;

   typedef struct packed {
      logic [pnp_pkg::CH_WIDTH-1:0] ch;
      logic                         last;
      logic                         empty;
   } char_word_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [pnp_pkg::BASE_WIDTH-1:0] base;
      logic [pnp_pkg::CH_WIDTH-1:0]   ch;
      logic                           last;
      logic                           empty;
      bit                             typed;
      pnp_pkg::result_type            want;
   } tb_row_type;

   localparam pnp_pkg::result_type NO_NUMBER  = '0;
   localparam pnp_pkg::result_type NUM_ERROR  = '{pnp_pkg::ST_ERROR, '0, '0, '0};
   localparam pnp_pkg::result_type QUOTE_FF   =
      '{pnp_pkg::ST_SINGLE, pnp_pkg::CELL_ONES, '0, '0};
   localparam pnp_pkg::result_type ERR_TAIL1  = '{pnp_pkg::ST_ERROR, '0, '0, 8'd1};
   localparam pnp_pkg::result_type NEG_ZERO_D =
      '{pnp_pkg::ST_DOUBLE, '0, pnp_pkg::CELL_ONES, '0};
   localparam pnp_pkg::result_type Z_BASE36   = '{pnp_pkg::ST_SINGLE, 32'd35, '0, '0};

   // directed words; a typed row carries its result, the rest go through the predictor
   localparam tb_row_type DIRECTED [0:28] = '{
      '{ROW_WORD, 6'd0,  8'h00,               1'b1, 1'b1, 1'b1, NUM_ERROR},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_HASH,    1'b1, 1'b0, 1'b1, NUM_ERROR},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_QUOTE,   1'b1, 1'b0, 1'b1, NUM_ERROR},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_DOLLAR,  1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_MINUS,   1'b1, 1'b0, 1'b1, NUM_ERROR},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_QUOTE,   1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  8'hFF,               1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_QUOTE,   1'b1, 1'b0, 1'b1, QUOTE_FF},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_QUOTE,   1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "x",                 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "y",                 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "z",                 1'b1, 1'b0, 1'b1, ERR_TAIL1},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_AMP,     1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_MINUS,   1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_DOT,     1'b1, 1'b0, 1'b1, NEG_ZERO_D},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "1",                 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "2",                 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "0",                 1'b1, 1'b0, 1'b1, ERR_TAIL1},
      '{ROW_WORD, 6'd0,  "1",                 1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  8'hFF,               1'b0, 1'b1, 1'b1, NUM_ERROR},
      '{ROW_CFG,  6'd36, 8'h00,               1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "z",                 1'b1, 1'b0, 1'b1, Z_BASE36},
      '{ROW_CFG,  6'd0,  8'h00,               1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "0",                 1'b1, 1'b0, 1'b1, NUM_ERROR},
      '{ROW_CFG,  6'd16, 8'h00,               1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  "F",                 1'b0, 1'b0, 1'b0, NO_NUMBER},
      // base change in the middle of a token must not touch its latched radix
      '{ROW_CFG,  6'd1,  8'h00,               1'b0, 1'b0, 1'b0, NO_NUMBER},
      '{ROW_WORD, 6'd0,  pnp_pkg::CH_DOT,     1'b1, 1'b0, 1'b0, NO_NUMBER}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en;
   logic [pnp_pkg::BASE_WIDTH-1:0] csr_wr_data;

   pnp_req_if req_bus ();
   pnp_rsp_if rsp_bus ();

   prefixed_number_parser_core #(
      .MAX_TOKEN_LENGTH(MAX_TOKEN_LEN)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pnp_pkg::result_type numbers_due [$];
   char_word_type       token_words [$];
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;
   bit                  no_idle = 1'b0;
   bit                  hold_results = 1'b0;

   // parser state as the block should hold it
   logic [pnp_pkg::BASE_WIDTH-1:0]   base_reg;
   parse_phase_type                  pst;
   logic [pnp_pkg::BASE_WIDTH-1:0]   tok_radix;
   logic [pnp_pkg::CELL_WIDTH-1:0]   tok_acc;
   logic                             tok_neg;
   logic [pnp_pkg::STATUS_WIDTH-1:0] tok_outcome;
   logic [pnp_pkg::COUNT_WIDTH-1:0]  tok_tail;

   function automatic void restart_token();
      pst         = WAIT_FIRST;
      tok_radix   = pnp_pkg::BASE_DEC;
      tok_acc     = '0;
      tok_neg     = 1'b0;
      tok_outcome = pnp_pkg::ST_SINGLE;
      tok_tail    = '0;
   endfunction

   function automatic void settle(input logic [pnp_pkg::STATUS_WIDTH-1:0] st,
                                  input logic [pnp_pkg::CELL_WIDTH-1:0] v, input logic n);
      tok_outcome = st;
      tok_acc     = v;
      tok_neg     = n;
      tok_tail    = '0;
      pst         = DECIDED;
   endfunction

   function automatic int digit_value(input logic [pnp_pkg::CH_WIDTH-1:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
      if (c >= "a" && c <= "z") return int'(c - "a") + 10;
      return 64;
   endfunction

   function automatic void eat_digit(input logic [pnp_pkg::CH_WIDTH-1:0] c, input logic last);
      int d;
      if (c == pnp_pkg::CH_DOT) begin
         settle(pnp_pkg::ST_DOUBLE, tok_neg ? -tok_acc : tok_acc, tok_neg);
         return;
      end
      d = digit_value(c);
      if (d >= int'(tok_radix)) begin
         settle(pnp_pkg::ST_ERROR, '0, 1'b0);
         return;
      end
      tok_acc = tok_acc * 32'(tok_radix) + 32'(d);
      if (last) settle(pnp_pkg::ST_SINGLE, tok_neg ? -tok_acc : tok_acc, 1'b0);
   endfunction

   function automatic void eat_sign(input logic [pnp_pkg::CH_WIDTH-1:0] c, input logic last);
      if (c == pnp_pkg::CH_MINUS) begin
         tok_neg = 1'b1;
         if (last) settle(pnp_pkg::ST_ERROR, '0, 1'b0);
         else pst = IN_DIGITS;
         return;
      end
      pst = IN_DIGITS;
      eat_digit(c, last);
   endfunction

   function automatic void parse_char(input char_word_type w, output bit gives,
                                      output pnp_pkg::result_type r);
      logic [pnp_pkg::CH_WIDTH-1:0] c;
      c = w.ch;
      r = '0;
      gives = 1'b1;
      if (w.empty) begin
         restart_token();
         r = NUM_ERROR;
         return;
      end
      case (pst)
         WAIT_FIRST: begin
            tok_neg = 1'b0;
            tok_acc = '0;
            if (c == pnp_pkg::CH_HASH || c == pnp_pkg::CH_AMP ||
                c == pnp_pkg::CH_DOLLAR || c == pnp_pkg::CH_PERCENT) begin
               tok_radix = (c == pnp_pkg::CH_DOLLAR) ? pnp_pkg::BASE_HEX :
                           (c == pnp_pkg::CH_PERCENT) ? pnp_pkg::BASE_BIN : pnp_pkg::BASE_DEC;
               if (w.last) settle(pnp_pkg::ST_ERROR, '0, 1'b0);
               else pst = WAIT_SIGN;
            end else if (c == pnp_pkg::CH_QUOTE) begin
               if (w.last) settle(pnp_pkg::ST_ERROR, '0, 1'b0);
               else pst = WAIT_QCHAR;
            end else begin
               tok_radix = base_reg;
               eat_sign(c, w.last);
            end
         end
         WAIT_QCHAR: begin
            tok_acc = {{24{c[7]}}, c};
            if (w.last) settle(pnp_pkg::ST_SINGLE, tok_acc, 1'b0);
            else pst = WAIT_QCLOSE;
         end
         WAIT_QCLOSE: begin
            if (c == pnp_pkg::CH_QUOTE) settle(pnp_pkg::ST_SINGLE, tok_acc, 1'b0);
            else settle(pnp_pkg::ST_ERROR, '0, 1'b0);
         end
         WAIT_SIGN: eat_sign(c, w.last);
         IN_DIGITS: eat_digit(c, w.last);
         default: begin
            if (tok_tail < MAX_TOKEN_LEN) tok_tail++;
         end
      endcase
      gives = w.last;
      if (!w.last) return;
      if (pst != DECIDED) settle(pnp_pkg::ST_ERROR, '0, 1'b0);
      r.status     = tok_outcome;
      r.value_low  = (tok_outcome == pnp_pkg::ST_ERROR) ? '0 : tok_acc;
      r.value_high = (tok_outcome == pnp_pkg::ST_DOUBLE && tok_neg) ? pnp_pkg::CELL_ONES : '0;
      r.remaining  = tok_tail;
      restart_token();
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [pnp_pkg::CH_WIDTH-1:0] digit_char(input int d);
      if (d < 10) return "0" + 8'(d);
      return ($urandom_range(0, 1) ? "a" : "A") + 8'(d - 10);
   endfunction

   function automatic void push_char(input logic [pnp_pkg::CH_WIDTH-1:0] c);
      token_words.push_back(char_word_type'{c, 1'b0, 1'b0});
   endfunction

   function automatic void push_noise(input int n);
      for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
   endfunction

   // builds one token into token_words, mostly well-formed numbers
   function automatic void make_token(input bit long_one);
      int kind;
      int n;
      int eff;
      token_words.delete();
      kind = long_one ? 0 : $urandom_range(0, 99);
      if (kind < 60) begin
         case ($urandom_range(0, 4))
            1: begin push_char(pnp_pkg::CH_HASH); eff = 10; end
            2: begin push_char(pnp_pkg::CH_AMP); eff = 10; end
            3: begin push_char(pnp_pkg::CH_DOLLAR); eff = 16; end
            4: begin push_char(pnp_pkg::CH_PERCENT); eff = 2; end
            default: eff = (base_reg > 36) ? 36 : int'(base_reg);
         endcase
         if ($urandom_range(0, 3) == 0) push_char(pnp_pkg::CH_MINUS);
         n = long_one ? 12 :
             ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
         for (int i = 0; i < n; i++)
            push_char(digit_char(eff == 0 ? $urandom_range(0, 35) : $urandom_range(0, eff - 1)));
         if ($urandom_range(0, 3) == 0) push_char(pnp_pkg::CH_DOT);
         // trailing junk drives the remaining count, long tokens saturate it
         n = long_one ? $urandom_range(260, 300) :
             ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
         push_noise(n);
      end else if (kind < 75) begin
         push_char(pnp_pkg::CH_QUOTE);
         if ($urandom_range(0, 7) != 0) begin
            push_char(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
               1: push_char(pnp_pkg::CH_QUOTE);
               2: begin
                  push_char(pnp_pkg::CH_QUOTE);
                  push_noise($urandom_range(1, 3));
               end
               3: push_noise($urandom_range(1, 3));
               default: ;
            endcase
         end
      end else if (kind < 92) begin
         push_noise($urandom_range(1, 6));
      end else begin
         // empty marker, sometimes dropping a token already under way
         push_noise($urandom_range(0, 2));
         token_words.push_back(char_word_type'{8'($urandom_range(0, 255)),
                                               1'($urandom_range(0, 1)), 1'b1});
         return;
      end
      token_words[token_words.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic send_word(input char_word_type w, input bit typed,
                            input pnp_pkg::result_type want);
      int                  gap;
      bit                  gives;
      pnp_pkg::result_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.ch          <= w.ch;
      req_bus.last_char   <= w.last;
      req_bus.empty_token <= w.empty;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parse_char(w, gives, pred);
      if (typed) numbers_due.push_back(want);
      else if (gives) numbers_due.push_back(pred);
   endtask

   // sender pauses until every number is back and the pipeline is empty
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (numbers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [pnp_pkg::BASE_WIDTH-1:0] b);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(posedge clock);
      base_reg = b;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [pnp_pkg::BASE_WIDTH-1:0] phase_base;
      int                             phase_items;
      req_bus.valid       <= 1'b0;
      req_bus.ch          <= '0;
      req_bus.last_char   <= 1'b0;
      req_bus.empty_token <= 1'b0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      base_reg = pnp_pkg::RESET_BASE;
      restart_token();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CFG) begin
            drain_results();
            write_base(DIRECTED[i].base);
         end else begin
            send_word(char_word_type'{DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].empty},
                      DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         phase_base = (p < 7) ? PHASE_BASES[p] : 6'($urandom_range(2, 36));
         write_base(phase_base);
         no_idle = (p == 1 || p == 5);
         // long receiver stall while words keep coming in
         if (p == 1) hold_results = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            make_token(phase_items == 0 && (p == 0 || p == 4));
            foreach (token_words[k]) send_word(token_words[k], 1'b0, NO_NUMBER);
            phase_items += token_words.size();
         end
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : result_ready
      int stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      pnp_pkg::result_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (numbers_due.size() == 0) begin
            report_mismatch("word with no number due", 64'(rsp_bus.value_low), 64'd0);
         end else begin
            due = numbers_due.pop_front();
            if (rsp_bus.status !== due.status)
               report_mismatch("status", 64'(rsp_bus.status), 64'(due.status));
            if (rsp_bus.value_low !== due.value_low)
               report_mismatch("value_low", 64'(rsp_bus.value_low), 64'(due.value_low));
            if (rsp_bus.value_high !== due.value_high)
               report_mismatch("value_high", 64'(rsp_bus.value_high), 64'(due.value_high));
            if (rsp_bus.remaining !== due.remaining)
               report_mismatch("remaining", 64'(rsp_bus.remaining), 64'(due.remaining));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
